// File: design/assert_macros.svh
// Assertion macros shared by the edge chain builder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ecb_pkg.sv
// Package: sizes, payload types, status codes and FSM states of the edge chain builder.
`default_nettype none

package ecb_pkg;

    // Store geometry and identity width
    localparam int STORE_DEPTH = 256;
    localparam int ID_BITS     = 16;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    typedef logic [ID_BITS-1:0] t_id;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_CLOSED     = 3'd1,
        ST_WAS_CLOSED = 3'd2,
        ST_DUP        = 3'd3,
        ST_NOT_ADJ    = 3'd4,
        ST_FULL       = 3'd5
    } t_status;

    // Input item; also the word kept in the edge store
    typedef struct packed {
        t_id edge_id;
        t_id vertex_a;
        t_id vertex_b;
    } t_item;

    // Result item
    typedef struct packed {
        t_status status;
        t_id     oriented_first;
        t_id     oriented_second;
        t_id     chain_first;
        t_id     chain_last;
        t_cnt    edge_count;
    } t_result;

    // Request from the controller to the duplicate scanner
    typedef struct packed {
        logic  go;
        t_addr head;
        t_cnt  count;
        t_item key;
    } t_scan_req;

    // Scanner answer, done is a one-cycle pulse
    typedef struct packed {
        logic done;
        logic dup;
    } t_scan_rsp;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN
    } t_state;

    // Where an edge joins the chain
    typedef enum logic [2:0] {
        JN_APPEND,
        JN_APPEND_FLIP,
        JN_PREPEND_FLIP,
        JN_PREPEND,
        JN_NONE
    } t_join;

endpackage

`default_nettype wire

// File: design/ecb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module ecb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                          i_wr_data,
    input  wire logic                                      i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/ecb_scan.sv
// Duplicate scanner: walks the stored edges from the head and compares each with the key.
`default_nettype none
`include "assert_macros.svh"

module ecb_scan
    import ecb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_scan_req i_req,
    output t_scan_rsp      o_rsp,
    output logic           o_rd_en,
    output t_addr          o_rd_addr,
    input  wire t_item     i_rd_data
);

    // Control registers
    logic  r_active, n_active;
    logic  r_pend,   n_pend;
    logic  r_done,   n_done;
    logic  r_dup,    n_dup;
    // Walk position and key
    t_cnt  r_idx,    n_idx;
    t_cnt  r_count,  n_count;
    t_addr r_addr,   n_addr;
    t_item r_key,    n_key;

    logic  w_hit;

    // Compare the entry that came back from the store with the key
    assign w_hit = r_pend &&
                   ((i_rd_data.edge_id == r_key.edge_id) ||
                    ((i_rd_data.vertex_a == r_key.vertex_a) &&
                     (i_rd_data.vertex_b == r_key.vertex_b)) ||
                    ((i_rd_data.vertex_a == r_key.vertex_b) &&
                     (i_rd_data.vertex_b == r_key.vertex_a)));

    // Next walk step: issue one read per cycle, stop on a hit or at the end
    always_comb begin
        n_active  = r_active;
        n_pend    = 1'b0;
        n_done    = 1'b0;
        n_dup     = r_dup;
        n_idx     = r_idx;
        n_count   = r_count;
        n_addr    = r_addr;
        n_key     = r_key;
        o_rd_en   = 1'b0;
        o_rd_addr = r_addr;
        if (i_req.go) begin
            n_active = 1'b1;
            n_dup    = 1'b0;
            n_idx    = '0;
            n_count  = i_req.count;
            n_addr   = i_req.head;
            n_key    = i_req.key;
        end else if (r_active) begin
            if (w_hit) begin
                n_active = 1'b0;
                n_done   = 1'b1;
                n_dup    = 1'b1;
            end else if (r_idx == r_count) begin
                n_active = 1'b0;
                n_done   = 1'b1;
                n_dup    = 1'b0;
            end else begin
                o_rd_en = 1'b1;
                n_pend  = 1'b1;
                n_idx   = r_idx + t_cnt'(1);
                n_addr  = (r_addr == t_addr'(STORE_DEPTH - 1)) ? '0 : r_addr + t_addr'(1);
            end
        end
    end

    // Control state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
            r_dup    <= 1'b0;
        end else begin
            r_active <= n_active;
            r_pend   <= n_pend;
            r_done   <= n_done;
            r_dup    <= n_dup;
        end
    end

    // Walk position and key
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_count <= n_count;
        r_addr  <= n_addr;
        r_key   <= n_key;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.dup  = r_dup;

    `ASSERT_SYNC(a_done_ends_walk, i_clk, i_rst_n, !(r_done && r_active), "scan done while still active")
    `ASSERT_SYNC(a_pend_in_walk, i_clk, i_rst_n, !r_pend || r_active || r_done, "read in flight outside a walk")
    `ASSERT_SYNC(a_read_in_range, i_clk, i_rst_n, !o_rd_en || (r_idx < r_count), "read beyond stored edges")

endmodule

`default_nettype wire

// File: design/edge_chain_builder.sv
// Top level: chain controller around the edge store and the duplicate scanner.
//
//  channel   ports                          transfer
//  --------  -----------------------------  --------------------------------
//  item in   start, busy, i_item            start high and busy low at edge
//  result    o_result_valid, o_result       one cycle, strobe high
//
// Empty or already closed chain: result decided in S_DECIDE and registered. Otherwise the store
// is walked from the head, one entry per cycle on the RAM read port, in S_SCAN; the walk
// ends at the last stored edge or early when a duplicate is hit, and the result is
// registered when the scanner's done pulse arrives. busy is high from the transfer until the strobe
// cycle; a new item may be taken in that cycle. Synchronous reset empties the chain; the
// store is not cleared, entries are read only after they were written.
`default_nettype none
`include "assert_macros.svh"

module edge_chain_builder
    import ecb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire t_item  i_item,
    output logic        o_result_valid,
    output t_result     o_result
);

    // Chain state
    t_state  r_state, n_state;
    logic    r_empty, n_empty;
    t_id     r_start, n_start;
    t_id     r_end,   n_end;
    t_addr   r_head,  n_head;
    t_cnt    r_count, n_count;
    // Current item and result
    t_item   r_in,    n_in;
    t_result r_result, n_result;
    logic    r_result_valid, n_result_valid;

    // Store access
    logic      w_wr_en;
    t_addr     w_wr_addr;
    t_item     w_wr_data;
    logic      w_rd_en;
    t_addr     w_rd_addr;
    t_item     w_rd_data;
    t_scan_req w_scan_req;
    t_scan_rsp w_scan_rsp;

    // Decision helpers
    logic               w_full;
    logic [SUM_W-1:0]   w_back_sum;
    t_addr              w_back_slot;
    t_addr              w_front_slot;
    t_join              w_join;
    logic               w_finish;
    t_status            w_status;
    t_id                w_of;
    t_id                w_os;

    assign w_full = (r_count >= t_cnt'(STORE_DEPTH));

    // Slot after the last edge and slot before the first edge
    assign w_back_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_back_slot = (w_back_sum >= SUM_W'(STORE_DEPTH))
                       ? ADDR_W'(w_back_sum - SUM_W'(STORE_DEPTH))
                       : ADDR_W'(w_back_sum);
    assign w_front_slot = (r_head == '0) ? t_addr'(STORE_DEPTH - 1) : r_head - t_addr'(1);

    // Which chain end the edge touches, first match wins
    always_comb begin
        if (r_end == r_in.vertex_a) begin
            w_join = JN_APPEND;
        end else if (r_end == r_in.vertex_b) begin
            w_join = JN_APPEND_FLIP;
        end else if (r_start == r_in.vertex_a) begin
            w_join = JN_PREPEND_FLIP;
        end else if (r_start == r_in.vertex_b) begin
            w_join = JN_PREPEND;
        end else begin
            w_join = JN_NONE;
        end
    end

    // Controller: next state, store write and result
    always_comb begin
        n_state        = r_state;
        n_empty        = r_empty;
        n_start        = r_start;
        n_end          = r_end;
        n_head         = r_head;
        n_count        = r_count;
        n_in           = r_in;
        n_result       = r_result;
        n_result_valid = 1'b0;
        w_wr_en        = 1'b0;
        w_wr_addr      = w_back_slot;
        w_wr_data      = r_in;
        w_finish       = 1'b0;
        w_status       = ST_OK;
        w_of           = r_in.vertex_a;
        w_os           = r_in.vertex_b;
        w_scan_req.go    = 1'b0;
        w_scan_req.head  = r_head;
        w_scan_req.count = r_count;
        w_scan_req.key   = r_in;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in    = i_item;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_empty) begin
                    w_finish = 1'b1;
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_wr_en  = 1'b1;
                        n_start  = r_in.vertex_a;
                        n_end    = r_in.vertex_b;
                        n_empty  = 1'b0;
                        n_count  = r_count + t_cnt'(1);
                        w_status = ST_OK;
                    end
                end else if (r_start == r_end) begin
                    w_finish = 1'b1;
                    w_status = ST_WAS_CLOSED;
                end else begin
                    w_scan_req.go = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_rsp.done) begin
                    w_finish = 1'b1;
                    if (w_scan_rsp.dup) begin
                        w_status = ST_DUP;
                    end else if (w_join == JN_NONE) begin
                        w_status = ST_NOT_ADJ;
                    end else if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        if (w_join == JN_APPEND_FLIP || w_join == JN_PREPEND_FLIP) begin
                            w_of = r_in.vertex_b;
                            w_os = r_in.vertex_a;
                        end
                        w_wr_en   = 1'b1;
                        w_wr_data = '{edge_id: r_in.edge_id, vertex_a: w_of, vertex_b: w_os};
                        n_count   = r_count + t_cnt'(1);
                        if (w_join == JN_APPEND || w_join == JN_APPEND_FLIP) begin
                            n_end = w_os;
                        end else begin
                            w_wr_addr = w_front_slot;
                            n_head    = w_front_slot;
                            n_start   = w_of;
                        end
                        w_status = (n_start == n_end) ? ST_CLOSED : ST_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Result reports the chain after this step
        if (w_finish) begin
            n_result.status          = w_status;
            n_result.oriented_first  = w_of;
            n_result.oriented_second = w_os;
            n_result.chain_first     = n_start;
            n_result.chain_last      = n_end;
            n_result.edge_count      = n_count;
            n_result_valid           = 1'b1;
            n_state                  = S_IDLE;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_empty        <= 1'b1;
            r_start        <= '0;
            r_end          <= '0;
            r_head         <= '0;
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_empty        <= n_empty;
            r_start        <= n_start;
            r_end          <= n_end;
            r_head         <= n_head;
            r_count        <= n_count;
            r_result_valid <= n_result_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_result <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    // Edge store
    ecb_ram #(
        .WIDTH ($bits(t_item)),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Duplicate search over the stored edges
    ecb_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_scan_req),
        .o_rsp     (w_scan_rsp),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    `ASSERT_SYNC(a_count_bound, i_clk, i_rst_n, r_count <= t_cnt'(STORE_DEPTH), "edge count above store depth")
    `ASSERT_SYNC(a_empty_count, i_clk, i_rst_n, !r_empty || (r_count == '0), "empty chain with stored edges")
    `ASSERT_SYNC(a_no_write_scan, i_clk, i_rst_n, !(w_wr_en && w_rd_en), "store write during duplicate walk")
    `ASSERT_NEXT(a_result_idles, i_clk, i_rst_n, n_result_valid, !busy, "busy still high with result strobe")

endmodule

`default_nettype wire

// File: test/tb_edge_chain_builder.sv
// Testbench for edge_chain_builder: directed edge table, then random chain building.
`timescale 1ns / 100ps

module tb_edge_chain_builder
    import ecb_pkg::*;
();

    localparam int TOTAL_ITEMS = 1150;
    localparam int N_DIRECTED  = 19;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        t_item   stim;
        logic    typed;
        t_result want;
    } t_dir_row;

    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        // first edge starts the chain, extreme vertices
        '{'{16'h0000, 16'h0000, 16'hFFFF}, 1'b1,
          '{ST_OK, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 9'd1}},
        // duplicate by id, by reversed pair, by exact pair
        '{'{16'h0000, 16'h0005, 16'h0006}, 1'b1,
          '{ST_DUP, 16'h0005, 16'h0006, 16'h0000, 16'hFFFF, 9'd1}},
        '{'{16'h0001, 16'hFFFF, 16'h0000}, 1'b1,
          '{ST_DUP, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 9'd1}},
        '{'{16'h0002, 16'h0000, 16'hFFFF}, 1'b1,
          '{ST_DUP, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 9'd1}},
        // touches neither end
        '{'{16'h0003, 16'h1234, 16'h5678}, 1'b1,
          '{ST_NOT_ADJ, 16'h1234, 16'h5678, 16'h0000, 16'hFFFF, 9'd1}},
        // append as given, append flipped, prepend flipped, prepend as given
        '{'{16'hFFFF, 16'hFFFF, 16'h0100}, 1'b0, '0},
        '{'{16'h8000, 16'h0200, 16'h0100}, 1'b0, '0},
        '{'{16'h0004, 16'h0000, 16'h0300}, 1'b0, '0},
        '{'{16'h7FFF, 16'h0400, 16'h0300}, 1'b0, '0},
        // self loops at either end
        '{'{16'h0010, 16'h0200, 16'h0200}, 1'b0, '0},
        '{'{16'h0011, 16'h0400, 16'h0400}, 1'b0, '0},
        // duplicate id wins over adjacency; reversed pair deep in the store
        '{'{16'h8000, 16'h0200, 16'h0500}, 1'b1,
          '{ST_DUP, 16'h0200, 16'h0500, 16'h0400, 16'h0200, 9'd7}},
        '{'{16'h0020, 16'h0200, 16'h0100}, 1'b1,
          '{ST_DUP, 16'h0200, 16'h0100, 16'h0400, 16'h0200, 9'd7}},
        '{'{16'h0021, 16'hFFFF, 16'hFFFE}, 1'b1,
          '{ST_NOT_ADJ, 16'hFFFF, 16'hFFFE, 16'h0400, 16'h0200, 9'd7}},
        '{'{16'h0022, 16'h0200, 16'h0000}, 1'b0, '0},
        '{'{16'hFFFE, 16'hFFFF, 16'h0400}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'h0000}, 1'b0, '0},
        // new id on a stored pair; interior vertices only
        '{'{16'h0030, 16'hFFFF, 16'h0400}, 1'b1,
          '{ST_DUP, 16'hFFFF, 16'h0400, 16'hFFFF, 16'hAAAA, 9'd10}},
        '{'{16'h0031, 16'h0300, 16'h0100}, 1'b1,
          '{ST_NOT_ADJ, 16'h0300, 16'h0100, 16'hFFFF, 16'hAAAA, 9'd10}}
    };

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_item   i_item  = '0;
    logic    o_result_valid;
    t_result o_result;

    // Chain model state
    logic    ch_empty = 1'b1;
    t_id     ch_start = '0;
    t_id     ch_end   = '0;
    t_addr   ch_head  = '0;
    t_cnt    ch_len   = '0;
    t_item   ch_mem [STORE_DEPTH];

    t_result pending_results [$];
    t_result want_r;
    int      mismatch_cnt = 0;

    edge_chain_builder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Store an oriented edge behind the chain's last edge
    function automatic void chain_push_back(input t_id id, input t_id va, input t_id vb);
        ch_mem[(ch_head + ch_len) % STORE_DEPTH] = '{id, va, vb};
        ch_len++;
    endfunction

    // Expected result of one edge; updates the chain model
    function automatic t_result predict_edge(input t_item it);
        t_result r;
        t_join   jn;
        t_item   e;
        logic    full;
        logic    dup;
        t_id     fa;
        t_id     fb;
        full     = (ch_len >= STORE_DEPTH);
        fa       = it.vertex_a;
        fb       = it.vertex_b;
        r.status = ST_OK;
        if (ch_empty) begin
            if (full) begin
                r.status = ST_FULL;
            end else begin
                chain_push_back(it.edge_id, fa, fb);
                ch_start = fa;
                ch_end   = fb;
                ch_empty = 1'b0;
            end
        end else if (ch_start == ch_end) begin
            r.status = ST_WAS_CLOSED;
        end else begin
            // duplicate walk over the stored edges, head first
            dup = 1'b0;
            for (int k = 0; k < ch_len; k++) begin
                e = ch_mem[(ch_head + k) % STORE_DEPTH];
                if (e.edge_id == it.edge_id
                    || (e.vertex_a == fa && e.vertex_b == fb)
                    || (e.vertex_a == fb && e.vertex_b == fa))
                    dup = 1'b1;
            end
            if (ch_end == fa)        jn = JN_APPEND;
            else if (ch_end == fb)   jn = JN_APPEND_FLIP;
            else if (ch_start == fa) jn = JN_PREPEND_FLIP;
            else if (ch_start == fb) jn = JN_PREPEND;
            else                     jn = JN_NONE;

            if (dup) begin
                r.status = ST_DUP;
            end else if (jn == JN_NONE) begin
                r.status = ST_NOT_ADJ;
            end else if (full) begin
                r.status = ST_FULL;
            end else begin
                if (jn == JN_APPEND_FLIP || jn == JN_PREPEND_FLIP) begin
                    fa = it.vertex_b;
                    fb = it.vertex_a;
                end
                if (jn == JN_APPEND || jn == JN_APPEND_FLIP) begin
                    chain_push_back(it.edge_id, fa, fb);
                    ch_end = fb;
                end else begin
                    ch_head = t_addr'((ch_head + STORE_DEPTH - 1) % STORE_DEPTH);
                    ch_mem[ch_head] = '{it.edge_id, fa, fb};
                    ch_len++;
                    ch_start = fa;
                end
                if (ch_start == ch_end) r.status = ST_CLOSED;
            end
        end
        r.oriented_first  = fa;
        r.oriented_second = fb;
        r.chain_first     = ch_start;
        r.chain_last      = ch_end;
        r.edge_count      = ch_len;
        return r;
    endfunction

    // Random vertex that is neither chain end
    function automatic t_id fresh_vertex();
        t_id v;
        do v = t_id'($urandom); while (v == ch_start || v == ch_end);
        return v;
    endfunction

    // Next random edge: mostly edges that grow the chain, the rest refusals and noise
    function automatic t_item draft_edge(input bit close_run);
        t_item       it;
        t_item       old;
        int unsigned roll;
        t_id         v;
        roll       = $urandom_range(0, 99);
        v          = fresh_vertex();
        it.edge_id = t_id'($urandom);
        it.vertex_a = t_id'($urandom);
        it.vertex_b = t_id'($urandom);
        if (ch_empty || ch_start == ch_end || roll >= 87) begin
            // empty or closed chain, or plain noise: fully random edge
        end else if (roll < 60) begin
            if (close_run && ch_len == STORE_DEPTH - 1) begin
                // closing edge, either orientation
                it.vertex_a = $urandom_range(0, 1) ? ch_end : ch_start;
                it.vertex_b = (it.vertex_a == ch_end) ? ch_start : ch_end;
            end else if (!close_run && ch_len == STORE_DEPTH && roll < 12) begin
                // touches both ends of a full store
                it.vertex_a = $urandom_range(0, 1) ? ch_end : ch_start;
                it.vertex_b = (it.vertex_a == ch_end) ? ch_start : ch_end;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: begin it.vertex_a = ch_end;   it.vertex_b = v;        end
                    2, 3: begin it.vertex_a = v;        it.vertex_b = ch_end;   end
                    4, 5: begin it.vertex_a = ch_start; it.vertex_b = v;        end
                    6, 7: begin it.vertex_a = v;        it.vertex_b = ch_start; end
                    8:    begin it.vertex_a = ch_end;   it.vertex_b = ch_end;   end
                    default: begin it.vertex_a = ch_start; it.vertex_b = ch_start; end
                endcase
            end
        end else if (roll < 75) begin
            // duplicate of a stored edge anywhere in the chain
            old = ch_mem[(ch_head + $urandom_range(0, ch_len - 1)) % STORE_DEPTH];
            case ($urandom_range(0, 2))
                0: begin
                    it.edge_id  = old.edge_id;
                    it.vertex_a = ch_end;
                    it.vertex_b = v;
                end
                1: begin
                    it.vertex_a = old.vertex_a;
                    it.vertex_b = old.vertex_b;
                end
                default: begin
                    it.vertex_a = old.vertex_b;
                    it.vertex_b = old.vertex_a;
                end
            endcase
        end else begin
            // touches neither end
            it.vertex_a = v;
            it.vertex_b = fresh_vertex();
        end
        return it;
    endfunction

    // Offer one edge after a random idle gap; predict at the transfer
    task automatic offer_edge(input t_item it, input logic typed, input t_result want,
                              input int unsigned idle_pct);
        int unsigned gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, STORE_DEPTH + 8);
        else
            while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap != 0) begin
            start  <= 1'b0;
            i_item <= t_item'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        // transfer taken at this edge
        want = typed ? want : predict_edge(it);
        if (typed) void'(predict_edge(it));
        pending_results.push_back(want);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result st=%0d of=%h os=%h cf=%h cl=%h n=%0d",
                             o_result.status, o_result.oriented_first,
                             o_result.oriented_second, o_result.chain_first,
                             o_result.chain_last, o_result.edge_count);
                mismatch_cnt++;
            end else begin
                want_r = pending_results.pop_front();
                if (o_result.status !== want_r.status
                    || o_result.oriented_first !== want_r.oriented_first
                    || o_result.oriented_second !== want_r.oriented_second
                    || o_result.chain_first !== want_r.chain_first
                    || o_result.chain_last !== want_r.chain_last
                    || o_result.edge_count !== want_r.edge_count) begin
                    if (mismatch_cnt < 10) begin
                        $display("result differs: exp st=%0d of=%h os=%h cf=%h cl=%h n=%0d",
                                 want_r.status, want_r.oriented_first,
                                 want_r.oriented_second, want_r.chain_first,
                                 want_r.chain_last, want_r.edge_count);
                        $display("                got st=%0d of=%h os=%h cf=%h cl=%h n=%0d",
                                 o_result.status, o_result.oriented_first,
                                 o_result.oriented_second, o_result.chain_first,
                                 o_result.chain_last, o_result.edge_count);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        bit          close_run;
        int unsigned pct;
        int unsigned waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // A chain can never reopen: a run either closes it one edge short of
        // full or fills the store and keeps offering edges to the full chain.
        close_run = $urandom_range(0, 1);
        for (int n = 0; n < TOTAL_ITEMS; n++) begin
            if (n < TOTAL_ITEMS / 3)          pct = 38;
            else if (n < 2 * TOTAL_ITEMS / 3) pct = 52;
            else                              pct = 0;
            if (n < N_DIRECTED)
                offer_edge(DIRECTED[n].stim, DIRECTED[n].typed, DIRECTED[n].want, pct);
            else
                offer_edge(draft_edge(close_run), 1'b0, '0, pct);
        end
        start <= 1'b0;

        // drain, then allow for one more full store walk
        waited = 0;
        while (pending_results.size() != 0 && waited < 4 * STORE_DEPTH) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (STORE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: 20 ms, several times the slowest correct run
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/ecb_pkg.sv
design/ecb_ram.sv
design/ecb_scan.sv
design/edge_chain_builder.sv
test/tb_edge_chain_builder.sv
